[sv/threshold_sample_router_macros.svh]
// assertion macros for the threshold sample router checker
`ifndef THRESHOLD_SAMPLE_ROUTER_MACROS_SVH
`define THRESHOLD_SAMPLE_ROUTER_MACROS_SVH

// property checked only outside reset
`define TSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/tsr_pkg.sv]
// shared types and constants for the threshold sample router
`default_nettype none

package tsr_pkg;

    localparam int DATA_W          = 16;
    localparam int NUM_LANES       = 4;
    localparam int LANE_W          = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_CLASSES_DEF = 256;
    // class index * 256 stays below 2^17, plus a sign bit
    localparam int LABEL_W         = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE  = 3'd4;

    localparam logic [0:0] CMD_LABEL = 1'b0;
    localparam logic [0:0] CMD_DATA  = 1'b1;

    // -1.0 in Q8.8
    localparam logic [DATA_W-1:0] IGNORE_LABEL = 16'hFF00;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
        logic                     last_score;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] lane_zero;
        logic signed [DATA_W-1:0] lane_one;
        logic signed [DATA_W-1:0] lane_two;
        logic signed [DATA_W-1:0] lane_three;
        logic        [LANE_W-1:0] selected_lane;
        logic                     ignored;
    } t_out_beat;

    typedef struct packed {
        logic                     train_mode;
        logic signed [DATA_W-1:0] threshold_a;
        logic signed [DATA_W-1:0] threshold_b;
        logic signed [DATA_W-1:0] threshold_c;
    } t_label_cfg;

    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic              ignored;
    } t_route;

endpackage

`default_nettype wire

[sv/tsr_label_unit.sv]
// label unit: running argmax of scores or train label, lane by thresholds
`default_nettype none

module tsr_label_unit #(
    parameter int MAX_CLASSES = tsr_pkg::MAX_CLASSES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tsr_pkg::t_label_cfg i_cfg,
    input  wire logic              i_label_valid,
    input  wire tsr_pkg::t_in_beat i_beat,
    output tsr_pkg::t_route        o_route
);
    import tsr_pkg::*;

    localparam int                CLS_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [CLS_W-1:0] CNT_LAST = CLS_W'(MAX_CLASSES - 1);

    logic signed [DATA_W-1:0] r_best_score, n_best_score;
    logic        [CLS_W-1:0]  r_best_class, n_best_class;
    logic        [CLS_W-1:0]  r_class_counter, n_class_counter;
    t_route                   r_route, n_route;

    logic signed [LABEL_W-1:0] label;
    logic                      set_route;
    logic                      label_ignored;
    logic [LANE_W-1:0]         label_lane;

    function automatic logic signed [LABEL_W-1:0] sext(input logic signed [DATA_W-1:0] v);
        sext = LABEL_W'(v);
    endfunction

    always_comb begin
        n_best_score    = r_best_score;
        n_best_class    = r_best_class;
        n_class_counter = r_class_counter;
        set_route       = 1'b0;

        if (i_label_valid) begin
            if (i_cfg.train_mode) begin
                n_class_counter = '0;
                set_route       = 1'b1;
            end else begin
                if (r_class_counter == '0) begin
                    n_best_score = i_beat.value;
                    n_best_class = '0;
                end else if (i_beat.value > r_best_score) begin
                    n_best_score = i_beat.value;
                    n_best_class = r_class_counter;
                end
                if (i_beat.last_score) begin
                    set_route       = 1'b1;
                    n_class_counter = '0;
                end else if (r_class_counter < CNT_LAST) begin
                    n_class_counter = r_class_counter + 1'b1;
                end
            end
        end
    end

    // class index read as Q8.8 index.0
    always_comb begin
        if (i_cfg.train_mode) begin
            label         = sext(i_beat.value);
            label_ignored = (i_beat.value == IGNORE_LABEL);
        end else begin
            label         = $signed({{(LABEL_W - 8 - CLS_W){1'b0}}, n_best_class, 8'h00});
            label_ignored = 1'b0;
        end

        if (label <= sext(i_cfg.threshold_a)) begin
            label_lane = 2'd0;
        end else if (label <= sext(i_cfg.threshold_b)) begin
            label_lane = 2'd1;
        end else if (label <= sext(i_cfg.threshold_c)) begin
            label_lane = 2'd2;
        end else begin
            label_lane = 2'd3;
        end

        n_route = r_route;
        if (set_route) begin
            n_route.ignored = label_ignored;
            n_route.lane    = label_ignored ? 2'd0 : label_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score    <= '0;
            r_best_class    <= '0;
            r_class_counter <= '0;
            r_route         <= '0;
        end else begin
            r_best_score    <= n_best_score;
            r_best_class    <= n_best_class;
            r_class_counter <= n_class_counter;
            r_route         <= n_route;
        end
    end

    assign o_route = r_route;

endmodule

`default_nettype wire

[sv/threshold_sample_router.sv]
// threshold sample router top level
//
// input channel: i_in_valid / o_in_stall carry t_in_beat. label beats (command 0)
// set the route of the sample: in train mode one beat gives the label, otherwise
// a run of class scores ending in last_score is reduced by argmax. data beats
// (command 1) each give one output beat on o_out_valid / i_out_stall.
// label beats give no output.
// a data beat accepted while the output is free is registered on o_out_data.
// throughput: one beat per cycle unless stalled, set by the output register and
// its one-entry skid stage; a label beat is folded into the state in its cycle.
// when the receiver stalls, the output beat holds and one more result goes to
// the skid stage; o_in_stall rises only while that stage is full.
// configuration: i_cfg_we writes register i_cfg_index (0 train_mode,
// 1..3 thresholds, 4 fill_value); unknown indexes are dropped. write only idle.
// reset (synchronous, active low) clears registers, argmax state and route
// (lane 0, not ignored) and empties the output stages; no clearing pass.
`default_nettype none

module threshold_sample_router #(
    parameter int MAX_CLASSES = tsr_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tsr_pkg::DATA_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire tsr_pkg::t_in_beat              i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output tsr_pkg::t_out_beat                  o_out_data,
    input  wire logic                           i_out_stall
);
    import tsr_pkg::*;

    t_label_cfg                r_cfg;
    logic signed [DATA_W-1:0]  r_fill_value;

    logic       r_out_valid;
    t_out_beat  r_out;
    logic       r_skid_valid;
    t_out_beat  r_skid;

    logic       in_accept;
    logic       push;
    logic       out_free;
    t_route     route;
    t_out_beat  n_beat;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign push      = in_accept && (i_in_data.command == CMD_DATA);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_fill_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRAIN_MODE:  r_cfg.train_mode  <= i_cfg_data[0];
                CFG_THRESHOLD_A: r_cfg.threshold_a <= i_cfg_data;
                CFG_THRESHOLD_B: r_cfg.threshold_b <= i_cfg_data;
                CFG_THRESHOLD_C: r_cfg.threshold_c <= i_cfg_data;
                CFG_FILL_VALUE:  r_fill_value      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tsr_label_unit #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_label (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_label_valid (in_accept && (i_in_data.command == CMD_LABEL)),
        .i_beat        (i_in_data),
        .o_route       (route)
    );

    // selected lane gets the data, all others the fill value; an ignored sample fills every lane
    always_comb begin
        n_beat.lane_zero  = (!route.ignored && route.lane == 2'd0) ? i_in_data.value : r_fill_value;
        n_beat.lane_one   = (!route.ignored && route.lane == 2'd1) ? i_in_data.value : r_fill_value;
        n_beat.lane_two   = (!route.ignored && route.lane == 2'd2) ? i_in_data.value : r_fill_value;
        n_beat.lane_three = (!route.ignored && route.lane == 2'd3) ? i_in_data.value : r_fill_value;
        n_beat.selected_lane = route.ignored ? 2'd0 : route.lane;
        n_beat.ignored       = route.ignored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_beat;
        end else if (push) begin
            r_skid <= n_beat;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[sv/tsr_checker.sv]
// port-level checker for the threshold sample router, bound to the top level
`default_nettype none
`include "threshold_sample_router_macros.svh"

module tsr_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cfg_we,
    input wire logic [tsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [tsr_pkg::DATA_W-1:0]    i_cfg_data,
    input wire logic                          i_in_valid,
    input wire tsr_pkg::t_in_beat             i_in_data,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire tsr_pkg::t_out_beat            o_out_data,
    input wire logic                          i_out_stall
);
    import tsr_pkg::*;

    logic cfg_seen;
    logic data_taken;
    logic lanes_alike;
    logic out_held;

    assign cfg_seen = i_cfg_we || (i_cfg_index != '0) || (i_cfg_data != '0) || 1'b1;

    assign data_taken  = i_in_valid && !o_in_stall && (i_in_data.command == CMD_DATA);
    assign lanes_alike = (o_out_data.lane_zero == o_out_data.lane_one)
                      && (o_out_data.lane_two == o_out_data.lane_three)
                      && (o_out_data.lane_zero == o_out_data.lane_two);
    assign out_held    = o_out_valid && i_out_stall;

    // no output beat right after reset
    `TSR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // an output beat that follows an idle output comes from a data beat taken the cycle before
    `TSR_ASSERT(a_out_from_data, $rose(o_out_valid) |-> $past(data_taken), "beat without data")

    // input stalls only while an output beat is waiting
    `TSR_ASSERT(a_stall_needs_out, cfg_seen && o_in_stall |-> o_out_valid, "stall with no output")

    // ignored sample fills every lane alike on lane 0
    `TSR_ASSERT(a_ignored_fill, o_out_valid && o_out_data.ignored |-> o_out_data.selected_lane == 2'd0 && lanes_alike, "ignored beat not filled")

    // stalled output beat holds
    `TSR_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(o_out_data), "stalled output changed")

endmodule

bind threshold_sample_router tsr_checker u_tsr_checker (.*);

`default_nettype wire
